// File: hdl/stable_sorted_priority_queue_assert.svh
// Assertion macros used by the queue top level.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Implication checked at every rising clock edge, held off during reset.
`define SSPQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define SSPQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sspq_pkg.sv
// Shared types and codes for the sorted priority queue.
`default_nettype none

package sspq_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned PRIO_W  = 16;
	localparam int unsigned OCC_W   = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_REMOVED   = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] item_value;
		logic [PRIO_W-1:0]         item_prio;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] out_value;
		logic [PRIO_W-1:0]         out_priority;
		logic [OCC_W-1:0]          occupancy;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic execute;
	} cmd_t;

	// datapath -> observers
	typedef struct packed {
		logic full;
		logic empty;
	} dp_status_t;

endpackage

`default_nettype wire

// File: hdl/sspq_ctrl.sv
// Sequencer: accepts a request, runs the store update, owns the result valid.
`default_nettype none

module sspq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output sspq_pkg::cmd_t     cmd
);

	sspq_pkg::state_t state_q, state_nxt;
	logic             rsp_valid_q;
	logic             slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sspq_pkg::S_IDLE: begin
				if (req_valid) begin
					state_nxt = sspq_pkg::S_EXEC;
				end
			end
			sspq_pkg::S_EXEC: begin
				if (slot_free) begin
					state_nxt = sspq_pkg::S_IDLE;
				end
			end
			default: state_nxt = sspq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		cmd.load_req = 1'b0;
		cmd.execute  = 1'b0;
		unique case (state_q)
			sspq_pkg::S_IDLE: begin
				req_ready    = 1'b1;
				cmd.load_req = req_valid;
			end
			sspq_pkg::S_EXEC: begin
				cmd.execute = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sspq_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.execute) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/sspq_dp.sv
// Datapath: request latch, row of sorted cells, entry count and result register.
`default_nettype none

module sspq_dp #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sspq_pkg::req_t    req,
	input  wire sspq_pkg::cmd_t    cmd,
	output sspq_pkg::rsp_t         rsp,
	output sspq_pkg::dp_status_t   st
);

	localparam int unsigned PW = sspq_pkg::PRIO_W;
	localparam int unsigned VW = sspq_pkg::VALUE_W;

	sspq_pkg::req_t           req_q;
	sspq_pkg::rsp_t           rsp_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_nxt;
	logic [PW-1:0]            prio_q  [DEPTH];
	logic signed [VW-1:0]     value_q [DEPTH];
	logic [DEPTH-1:0]         le;
	logic                     full, empty;
	logic                     do_ins, do_rem;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign st.full  = full;
	assign st.empty = empty;
	assign rsp = rsp_q;

	assign do_ins = cmd.execute && (req_q.op == sspq_pkg::OP_INSERT) && !full;
	assign do_rem = cmd.execute && (req_q.op == sspq_pkg::OP_REMOVE) && !empty;

	// per cell: occupied and ordered at or ahead of the new priority
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			le[i] = (CW'(i) < count_q) && (prio_q[i] <= req_q.item_prio);
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CW'(1);
		end else if (do_rem) begin
			count_nxt = count_q - CW'(1);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                 left_le;
		logic [PW-1:0]        up_p, dn_p;
		logic signed [VW-1:0] up_v, dn_v;

		if (g == 0) begin : g_first
			assign left_le = 1'b1;
			assign up_p    = prio_q[g];
			assign up_v    = value_q[g];
		end else begin : g_mid
			assign left_le = le[g-1];
			assign up_p    = prio_q[g-1];
			assign up_v    = value_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign dn_p = prio_q[g];
			assign dn_v = value_q[g];
		end else begin : g_inner
			assign dn_p = prio_q[g+1];
			assign dn_v = value_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (do_ins && !le[g]) begin
				if (left_le) begin
					prio_q[g]  <= req_q.item_prio;
					value_q[g] <= req_q.item_value;
				end else begin
					prio_q[g]  <= up_p;
					value_q[g] <= up_v;
				end
			end else if (do_rem) begin
				prio_q[g]  <= dn_p;
				value_q[g] <= dn_v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.execute) begin
			rsp_q.out_value    <= '0;
			rsp_q.out_priority <= '0;
			rsp_q.occupancy    <= sspq_pkg::OCC_W'(count_nxt);
			unique case (req_q.op)
				sspq_pkg::OP_INSERT: begin
					rsp_q.status <= full ? sspq_pkg::ST_OVERFLOW : sspq_pkg::ST_INSERTED;
				end
				sspq_pkg::OP_REMOVE: begin
					if (empty) begin
						rsp_q.status <= sspq_pkg::ST_UNDERFLOW;
					end else begin
						rsp_q.status       <= sspq_pkg::ST_REMOVED;
						rsp_q.out_value    <= value_q[0];
						rsp_q.out_priority <= prio_q[0];
					end
				end
				default: rsp_q.status <= sspq_pkg::ST_UNDERFLOW;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue: sequencer plus row of sorted cells.
// A request beat is latched in IDLE; EXEC then updates the store and loads the result
// register and result valid once the result slot is free. No new request is taken until then;
// a waiting result only stalls the update step, not the request latch.
// Reset: arst_n clears the entry count, sequencer state and result valid; cell contents stay.
`default_nettype none

module stable_sorted_priority_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire sspq_pkg::req_t   req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output sspq_pkg::rsp_t        rsp
);

	// Count is wide enough to hold DEPTH itself; the occupancy field takes its low bits.
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sspq_pkg::cmd_t       cmd;
	sspq_pkg::dp_status_t dp_st;

	// result decodes used by the checks at the end
	logic rsp_is_ovf, rsp_is_udf, udf_ok;

	// Sequencer: IDLE latches a request beat, EXEC applies it once the result slot is free.
	sspq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// Each cell compares its priority with the new one; an insert opens a gap after the
	// last cell that is less or equal, so equal priorities keep arrival order. A remove
	// shifts every cell one place toward the front.
	sspq_dp #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.rsp    (rsp),
		.st     (dp_st)
	);

	assign rsp_is_ovf = (rsp.status == sspq_pkg::ST_OVERFLOW);
	assign rsp_is_udf = (rsp.status == sspq_pkg::ST_UNDERFLOW);
	assign udf_ok     = dp_st.empty && (rsp.occupancy == '0);

`include "stable_sorted_priority_queue_assert.svh"

	// one request in flight at a time
	`SSPQ_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "taken while busy")
	// a fresh overflow result means the store is still full
	`SSPQ_ASSERT_IMP(a_overflow_full, $rose(rsp_valid) && rsp_is_ovf, dp_st.full, "overflow, room left")
	// a fresh underflow result means the store is still empty
	`SSPQ_ASSERT_IMP(a_underflow_empty, $rose(rsp_valid) && rsp_is_udf, udf_ok, "underflow, entries held")

endmodule

`default_nettype wire

// File: verif/stable_sorted_priority_queue_tb.sv
// Testbench for the stable sorted priority queue: directed and random beats checked against a model.

module stable_sorted_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PQ_DEPTH     = 16;
	localparam int unsigned SETTLE_CYCLES = 10;   // idle wait after all results are drained
	localparam int unsigned TIMEOUT_NS   = 1000000;
	localparam int unsigned MAX_REPORTS  = 10;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	sspq_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	sspq_pkg::rsp_t rsp;

	// Model of the sorted store: front of each queue is the next entry to leave.
	logic [sspq_pkg::PRIO_W-1:0]         model_prio[$];
	logic signed [sspq_pkg::VALUE_W-1:0] model_value[$];

	// Results predicted for accepted requests, oldest first.
	sspq_pkg::rsp_t awaited_rsp_q[$];

	int unsigned mismatch_count = 0;

	// Sender burst control.
	bit          sender_idle_en = 1'b0;
	int unsigned burst_left     = 0;

	// Receiver stall pattern: a 16-bit mask walked one bit per cycle, refreshed when the tick wraps.
	logic        receiver_stall_en = 1'b0;
	logic [15:0] stall_pattern     = 16'hffff;
	logic [5:0]  stall_tick        = '0;

	always #1 clk = ~clk;

	stable_sorted_priority_queue #(
		.DEPTH(PQ_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Work out the result of one accepted request and advance the model store.
	function automatic sspq_pkg::rsp_t predict_pq_result(input sspq_pkg::req_t r);
		sspq_pkg::rsp_t res;
		int unsigned    pos;
		res = '0;
		if (r.op == sspq_pkg::OP_INSERT) begin
			if (model_prio.size() >= PQ_DEPTH) begin
				res.status = sspq_pkg::ST_OVERFLOW;
			end else begin
				// land behind every entry with priority <= ours, so ties stay in arrival order
				pos = 0;
				while (pos < model_prio.size() && model_prio[pos] <= r.item_prio)
					pos++;
				model_prio.insert(pos, r.item_prio);
				model_value.insert(pos, r.item_value);
				res.status = sspq_pkg::ST_INSERTED;
			end
		end else if (model_prio.size() == 0) begin
			res.status = sspq_pkg::ST_UNDERFLOW;
		end else begin
			res.status       = sspq_pkg::ST_REMOVED;
			res.out_value    = model_value.pop_front();
			res.out_priority = model_prio.pop_front();
		end
		// count is carried modulo the field width
		res.occupancy = sspq_pkg::OCC_W'(model_prio.size());
		return res;
	endfunction

	function automatic void note_mismatch(input string what, input sspq_pkg::rsp_t want,
		input sspq_pkg::rsp_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s: expected status=%0d value=%0d prio=%0d occ=%0d",
				$realtime, what, want.status, want.out_value, want.out_priority, want.occupancy);
			$display("%0t: %s: got      status=%0d value=%0d prio=%0d occ=%0d",
				$realtime, what, got.status, got.out_value, got.out_priority, got.occupancy);
		end
	endfunction

	// Receiver: ready follows the stall pattern, or stays high when stalls are off.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (!receiver_stall_en) begin
			rsp_ready <= 1'b1;
		end else begin
			if (stall_tick == '0)
				// now and then a near-solid stall to back the block up
				stall_pattern <= ($urandom_range(0, 7) == 0) ? 16'h0001 : 16'($urandom);
			rsp_ready <= stall_pattern[stall_tick[3:0]];
		end
	end

	// Result checker: every beat taken on the result side is matched against the oldest prediction.
	always @(posedge clk) begin
		sspq_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp_q.size() == 0) begin
				note_mismatch("result beat with nothing awaited", '0, rsp);
			end else begin
				want = awaited_rsp_q.pop_front();
				if (rsp.status !== want.status || rsp.out_value !== want.out_value ||
				    rsp.out_priority !== want.out_priority || rsp.occupancy !== want.occupancy)
					note_mismatch("result mismatch", want, rsp);
			end
		end
	end

	// Send one request beat. Valid stays high after acceptance so the next beat can
	// follow back to back; a gap or a drain lowers it in the same step.
	task automatic send_request(input sspq_pkg::req_t item);
		int unsigned gap;
		if (sender_idle_en && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left != 0)
			burst_left--;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		awaited_rsp_q.push_back(predict_pq_result(item));
	endtask

	// Hold off the sender until every predicted result has been seen, then let the block settle.
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (awaited_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic sspq_pkg::req_t make_request(input sspq_pkg::op_t op, input int value,
		input int unsigned prio);
		sspq_pkg::req_t r;
		r.op         = op;
		r.item_value = value;
		r.item_prio  = sspq_pkg::PRIO_W'(prio);
		return r;
	endfunction

	function automatic sspq_pkg::req_t make_random_request(input int unsigned insert_pct);
		sspq_pkg::req_t r;
		r.op = ($urandom_range(0, 99) < insert_pct) ? sspq_pkg::OP_INSERT : sspq_pkg::OP_REMOVE;
		case ($urandom_range(0, 3))
			0: r.item_prio = sspq_pkg::PRIO_W'($urandom_range(0, 65535));
			1: r.item_prio = sspq_pkg::PRIO_W'($urandom_range(0, 3));        // dense ties
			2: r.item_prio = $urandom_range(0, 1) ? '1 : '0;
			default: r.item_prio = sspq_pkg::PRIO_W'($urandom_range(100, 107));
		endcase
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: r.item_value = 32'sh8000_0000;
				1: r.item_value = 32'sh7fff_ffff;
				2: r.item_value = '0;
				default: r.item_value = '1;
			endcase
		end else begin
			r.item_value = $urandom;
		end
		return r;
	endfunction

	// Remove on an empty queue; payload fields are nonzero and must be ignored.
	task automatic test_remove_empty();
		send_request(make_request(sspq_pkg::OP_REMOVE, 32'sh1234_5678, 16'hbeef));
	endtask

	// Value and priority extremes, with equal priorities to check arrival order on exit.
	task automatic test_extremes_and_ties();
		send_request(make_request(sspq_pkg::OP_INSERT, 32'sh7fff_ffff, 16'hffff));
		send_request(make_request(sspq_pkg::OP_INSERT, 32'sh8000_0000, 16'h0000));
		send_request(make_request(sspq_pkg::OP_INSERT, -1,             16'hffff));
		send_request(make_request(sspq_pkg::OP_INSERT, 0,              16'h0000));
		repeat (4) send_request(make_request(sspq_pkg::OP_REMOVE, -1, 16'hffff));
		test_remove_empty();
	endtask

	// Fill to capacity, then an insert with the lowest priority value must be refused.
	task automatic test_full_overflow();
		repeat (PQ_DEPTH)
			send_request(make_request(sspq_pkg::OP_INSERT, $urandom, $urandom_range(0, 3)));
		send_request(make_request(sspq_pkg::OP_INSERT, 32'sh5555_aaaa, 16'h0000));
	endtask

	// Random traffic with bursty sender and stalling receiver; the insert mix drifts
	// between filling and draining so both full and empty are visited often.
	task automatic test_random_traffic(input int unsigned count);
		int unsigned insert_pct;
		insert_pct = 50;
		for (int unsigned k = 0; k < count; k++) begin
			if (k % 48 == 0) begin
				case ($urandom_range(0, 3))
					0: insert_pct = 85;
					1: insert_pct = 15;
					2: insert_pct = 55;
					default: insert_pct = 70;
				endcase
			end
			send_request(make_random_request(insert_pct));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, no idling
		test_remove_empty();
		test_extremes_and_ties();
		test_full_overflow();
		wait_results_drained();

		// random with gaps on both sides
		sender_idle_en    = 1'b1;
		receiver_stall_en <= 1'b1;
		test_random_traffic(350);
		wait_results_drained();
		test_random_traffic(350);

		// stretch with no idling at all
		sender_idle_en    = 1'b0;
		receiver_stall_en <= 1'b0;
		test_random_traffic(200);

		// sender back to back against a stalling receiver
		receiver_stall_en <= 1'b1;
		test_random_traffic(100);

		wait_results_drained();
		if (mismatch_count == 0) begin
			$display("stable_sorted_priority_queue test passed");
		end else begin
			$display("stable_sorted_priority_queue test failed");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("stable_sorted_priority_queue test failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/sspq_pkg.sv
hdl/sspq_ctrl.sv
hdl/sspq_dp.sv
hdl/stable_sorted_priority_queue.sv
verif/stable_sorted_priority_queue_tb.sv
